### rtl/ddfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddfe_pkg
// Shared constants and types for the decimal digit frame emitter.
// ----------------------------------------------------------------------------
package ddfe_pkg;

    localparam int VALUE_W     = 32;
    localparam int NIBBLE_W    = 4;
    localparam int FRAME_W     = 16;
    localparam int DIGIT_COUNT = 8;
    localparam int POS_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ceil(2^35 / 10): floor(x * RECIP_TEN / 2^35) == x / 10 for any 32-bit x.
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGIT_COUNT - 1);

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } t_queue_head;

endpackage

### rtl/decimal_digit_frame_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_digit_frame_emitter
// Splits 32-bit binary words into eight decimal digit display frames.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready with i_value. Output channel:
// o_out_valid / i_out_ready with the digit address, digit, frame word and
// last flag. Each accepted word yields eight frames, least significant
// digit first at address 1, the eighth carrying last; digits above the
// eighth are dropped, so the value shows modulo 100000000.
// Accepted words wait in a two-entry queue. The digit engine produces one
// frame per cycle while the receiver takes them, through a single
// reciprocal multiplier, and words follow one another with no gap. When
// the engine is free, a word passes from the queue into the engine's value
// register and its first frame then into the output frame register.
// A stalled receiver holds the registered frame and the engine pauses;
// the queue keeps taking words until both entries are full.
// Synchronous reset empties the queue and drops any frame in flight.
// ----------------------------------------------------------------------------
module decimal_digit_frame_emitter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ddfe_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ddfe_pkg::NIBBLE_W-1:0] o_digit_address,
    output logic [ddfe_pkg::NIBBLE_W-1:0] o_digit_value,
    output logic [ddfe_pkg::FRAME_W-1:0]  o_frame_word,
    output logic                          o_last
);
    import ddfe_pkg::*;

    t_queue_head head;
    logic        pop;

    ddfe_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_in_valid),
        .o_wr_ready (o_in_ready),
        .i_wr_value (i_value),
        .o_head     (head),
        .i_pop      (pop)
    );

    ddfe_digit_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_digit_address (o_digit_address),
        .o_digit_value   (o_digit_value),
        .o_frame_word    (o_frame_word),
        .o_last          (o_last)
    );

endmodule

### rtl/ddfe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddfe_queue
// Short register queue between the accepting front and the digit engine.
// ----------------------------------------------------------------------------
module ddfe_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_valid,
    output logic                         o_wr_ready,
    input  logic [ddfe_pkg::VALUE_W-1:0] i_wr_value,
    output ddfe_pkg::t_queue_head        o_head,
    input  logic                         i_pop
);
    import ddfe_pkg::*;

    logic [VALUE_W-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               wr_en;
    logic               rd_en;

    assign o_wr_ready   = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign wr_en        = i_wr_valid && o_wr_ready;
    assign rd_en        = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.value = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/ddfe_digit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddfe_digit_engine
// Peels one decimal digit per cycle, while the output is not stalled, off
// the current value and registers the resulting display frame for the output channel.
// ----------------------------------------------------------------------------
module ddfe_digit_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ddfe_pkg::t_queue_head         i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ddfe_pkg::NIBBLE_W-1:0] o_digit_address,
    output logic [ddfe_pkg::NIBBLE_W-1:0] o_digit_value,
    output logic [ddfe_pkg::FRAME_W-1:0]  o_frame_word,
    output logic                          o_last
);
    import ddfe_pkg::*;

    logic                    r_busy;
    logic [VALUE_W-1:0]      r_rest;
    logic [POS_W-1:0]        r_pos;
    logic                    r_out_valid;
    logic [NIBBLE_W-1:0]     r_addr;
    logic [NIBBLE_W-1:0]     r_digit;
    logic                    r_last;

    logic [2*VALUE_W-1:0]    product;
    logic [VALUE_W-1:0]      n_rest;
    logic [VALUE_W-1:0]      times_ten;
    logic [VALUE_W-1:0]      remainder;
    logic                    step;
    logic                    at_last;
    logic                    load;

    // Quotient by reciprocal multiply; the remainder is what is left over.
    assign product   = r_rest * {{VALUE_W{1'b0}}, RECIP_TEN};
    assign n_rest    = VALUE_W'(product >> RECIP_SHIFT);
    assign times_ten = {n_rest[VALUE_W-4:0], 3'b000} + {n_rest[VALUE_W-2:0], 1'b0};
    assign remainder = r_rest - times_ten;

    assign step    = r_busy && (!r_out_valid || i_ready);
    assign at_last = (r_pos == LAST_POS);
    // A new word is loaded on the very cycle the last digit leaves.
    assign load    = i_head.valid && (!r_busy || (step && at_last));
    assign o_pop   = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
            end else if (step && at_last) begin
                r_busy <= 1'b0;
            end else if (step) begin
                r_pos  <= r_pos + 1'b1;
            end

            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rest <= i_head.value;
        end else if (step) begin
            r_rest <= n_rest;
        end
        if (step) begin
            r_addr  <= NIBBLE_W'(r_pos) + 1'b1;
            r_digit <= remainder[NIBBLE_W-1:0];
            r_last  <= at_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_digit_address = r_addr;
    assign o_digit_value   = r_digit;
    assign o_frame_word    = {4'b0000, r_addr, 4'b0000, r_digit};
    assign o_last          = r_last;

endmodule

### test/ddfe_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddfe_frame_checker
// Predicts and checks the digit frames of the decimal digit frame emitter.
// ----------------------------------------------------------------------------
// Watches both channels. Every word taken on the input adds its frames to
// a queue of expected frames. Every frame taken on the output is compared
// field by field with the oldest one in the queue. Counts go back to the
// testbench top as registered values.
// ----------------------------------------------------------------------------
module ddfe_frame_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [ddfe_pkg::VALUE_W-1:0]  i_value,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [ddfe_pkg::NIBBLE_W-1:0] i_digit_address,
    input  logic [ddfe_pkg::NIBBLE_W-1:0] i_digit_value,
    input  logic [ddfe_pkg::FRAME_W-1:0]  i_frame_word,
    input  logic                          i_last,
    output int                            o_fail_count,
    output int                            o_frames_pending,
    output int                            o_words_taken,
    output int                            o_frames_checked
);

    typedef struct packed {
        logic [ddfe_pkg::NIBBLE_W-1:0] address;
        logic [ddfe_pkg::NIBBLE_W-1:0] digit;
        logic [ddfe_pkg::FRAME_W-1:0]  word;
        logic                          last;
    } t_digit_frame;

    t_digit_frame expected_frames[$];
    int           fails   = 0;
    int           words   = 0;
    int           checked = 0;

    initial begin
        o_fail_count     = 0;
        o_frames_pending = 0;
        o_words_taken    = 0;
        o_frames_checked = 0;
    end

    // Splits one word into its decimal digits, least significant first.
    function automatic void predict_digit_frames(input logic [ddfe_pkg::VALUE_W-1:0] v);
        logic [ddfe_pkg::VALUE_W-1:0] rest;
        t_digit_frame                 f;
        int                           frames;
        int                           k;
        rest   = v;
        frames = ddfe_pkg::DIGIT_COUNT;
        if (frames < 1) begin
            frames = 1;
        end
        if (frames > 8) begin
            frames = 8;
        end
        for (k = 0; k < frames; k++) begin
            f.digit   = ddfe_pkg::NIBBLE_W'(rest % 10);
            rest      = rest / 10;
            f.address = ddfe_pkg::NIBBLE_W'(k + 1);
            f.word    = {8'(f.address), 8'(f.digit)};
            f.last    = (k == frames - 1);
            expected_frames.push_back(f);
        end
    endfunction

    always @(posedge i_clk) begin
        t_digit_frame want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_frames.size() == 0) begin
                    $error("frame with address %0d digit %0d arrived with none expected",
                           i_digit_address, i_digit_value);
                    fails++;
                end else begin
                    want = expected_frames.pop_front();
                    checked++;
                    if (i_digit_address !== want.address) begin
                        $error("digit_address: expected %0d, got %0d",
                               want.address, i_digit_address);
                        fails++;
                    end
                    if (i_digit_value !== want.digit) begin
                        $error("digit_value: expected %0d, got %0d",
                               want.digit, i_digit_value);
                        fails++;
                    end
                    if (i_frame_word !== want.word) begin
                        $error("frame_word: expected 0x%04h, got 0x%04h",
                               want.word, i_frame_word);
                        fails++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_last);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_digit_frames(i_value);
                words++;
            end
        end
        o_fail_count     <= fails;
        o_frames_pending <= expected_frames.size();
        o_words_taken    <= words;
        o_frames_checked <= checked;
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the decimal digit frame emitter.
// ----------------------------------------------------------------------------
// Sends a directed set of words (zero, single digits, powers of ten, the
// largest value that shows whole, values too large to show, all ones),
// then bursts of random words. The receiver stalls on its own pattern and
// once holds off for a long stretch while words keep coming. Checking is
// done by ddfe_frame_checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WORD_TOTAL  = 310;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 90;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_in_valid      = 1'b0;
    logic [ddfe_pkg::VALUE_W-1:0]  i_value         = '0;
    logic                          i_out_ready     = 1'b0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic [ddfe_pkg::NIBBLE_W-1:0] o_digit_address;
    logic [ddfe_pkg::NIBBLE_W-1:0] o_digit_value;
    logic [ddfe_pkg::FRAME_W-1:0]  o_frame_word;
    logic                          o_last;

    int fail_count;
    int frames_pending;
    int words_taken;
    int frames_checked;
    int words_sent     = 0;
    int cycle_count    = 0;
    int hold_requests  = 0;

    decimal_digit_frame_emitter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_digit_address (o_digit_address),
        .o_digit_value   (o_digit_value),
        .o_frame_word    (o_frame_word),
        .o_last          (o_last)
    );

    ddfe_frame_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_value          (i_value),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_digit_address  (o_digit_address),
        .i_digit_value    (o_digit_value),
        .i_frame_word     (o_frame_word),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_frames_pending (frames_pending),
        .o_words_taken    (words_taken),
        .o_frames_checked (frames_checked)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d frames outstanding.",
                     cycle_count, frames_pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: a stall pattern that changes every so often, with some
    // stretches never stalling, and a long hold-off on request.
    int rx_phase  = 0;
    int rx_period = 1;
    int rx_busy   = 0;
    int rx_age    = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_age == 0) begin
                rx_age    = $urandom_range(20, 80);
                rx_period = $urandom_range(1, 8);
                rx_busy   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rx_period - 1);
                rx_phase  = 0;
            end
            rx_age--;
            i_out_ready <= (rx_phase >= rx_busy);
            rx_phase = (rx_phase + 1) % rx_period;
        end
    end

    // Holds valid and the word until the block takes it.
    task automatic offer_word(input logic [ddfe_pkg::VALUE_W-1:0] v);
        i_in_valid <= 1'b1;
        i_value    <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic rest_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (frames_pending != 0) @(posedge i_clk);
    endtask

    // Mostly values that fit the display, many from the full range, and
    // some around powers of ten.
    function automatic logic [ddfe_pkg::VALUE_W-1:0] pick_value();
        logic [ddfe_pkg::VALUE_W-1:0] p;
        int                           k;
        int                           n;
        p = 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pick_value = $urandom_range(0, 99999999);
            4:          pick_value = $urandom_range(0, 999);
            5: begin
                n = $urandom_range(0, 9);
                for (k = 0; k < n; k++) begin
                    p = p * 10;
                end
                pick_value = p + $urandom_range(0, 2) - 1;
            end
            default:    pick_value = $urandom;
        endcase
    endfunction

    logic [ddfe_pkg::VALUE_W-1:0] directed_words[] = '{
        32'd0, 32'd5, 32'd9, 32'd10, 32'd99, 32'd100, 32'd12345678, 32'd87654321,
        32'd99999999, 32'd100000000, 32'd100000001, 32'd999999999, 32'd1000000000,
        32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
        32'd90909090, 32'd10000000, 32'd1
    };

    initial begin
        int burst;
        int j;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_words[j]) begin
            offer_word(directed_words[j]);
            if ($urandom_range(0, 3) == 0) begin
                rest_sender($urandom_range(1, 12));
            end
        end
        wait_for_drain();

        // The receiver holds off while a run of words keeps coming, so the
        // queue fills and the input stalls.
        hold_requests++;
        for (j = 0; j < 12; j++) begin
            offer_word(pick_value());
        end
        wait_for_drain();

        while (words_sent < WORD_TOTAL) begin
            burst = $urandom_range(1, 12);
            for (j = 0; j < burst && words_sent < WORD_TOTAL; j++) begin
                offer_word(pick_value());
            end
            if ($urandom_range(0, 2) != 0) begin
                rest_sender($urandom_range(1, 20));
            end
        end
        wait_for_drain();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d words, %0d taken, %0d frames checked.",
                 words_sent, words_taken, frames_checked);
        $display("Included digit extremes, overflowing values, a long output hold-off.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/ddfe_pkg.sv
rtl/ddfe_queue.sv
rtl/ddfe_digit_engine.sv
rtl/decimal_digit_frame_emitter.sv
test/ddfe_frame_checker.sv
test/tb_top.sv
